>>> src/invoice_amount_parser_assert.svh
// Assertion macros shared by the invoice amount parser RTL.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef INVOICE_AMOUNT_PARSER_ASSERT_SVH
`define INVOICE_AMOUNT_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// property holds at every rising clock edge outside reset
`define IAP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition never seen at a rising clock edge outside reset
`define IAP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IAP_ASSERT(lbl, clk, rst_n, prop, msg)
`define IAP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> src/iap_pkg.sv
// Package for the invoice amount parser: widths, codes, the parse phase and the
// snapshot type passed from the parse stage to the scale stage. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iap_pkg;

	localparam int CHAR_W         = 8;
	localparam int ACC_W          = 40;
	localparam int FACTOR_W       = 17;
	localparam int SAT_W          = ACC_W + FACTOR_W;
	localparam int CNT_W          = 4;
	localparam int FLASH_W        = 5;
	localparam int MAX_DIGITS_DEF = 12;

	localparam logic [FACTOR_W-1:0] FACTOR_M   = FACTOR_W'(100000);
	localparam logic [FACTOR_W-1:0] FACTOR_U   = FACTOR_W'(100);
	localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_DIGITS = 2'd1,
		ST_UNIT_ERR  = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// parse phase of the character state machine
	typedef enum logic [1:0] {
		PH_SEEK_DIGIT = 2'd0,
		PH_DIGITS     = 2'd1,
		PH_SEEK_UNIT  = 2'd2,
		PH_DONE       = 2'd3
	} phase_t;

	// multiplier selection for the scale stage
	typedef enum logic [1:0] {
		SC_ONE = 2'd0,
		SC_U   = 2'd1,
		SC_M   = 2'd2
	} scale_t;

	// one finished invoice, ready for scaling
	typedef struct packed {
		status_t             status;
		logic [ACC_W-1:0]    operand;
		scale_t              scale;
		logic [FLASH_W-1:0]  flash;
	} snap_t;

endpackage

`default_nettype wire

>>> src/iap_parse.sv
// Character parser: digit run accumulation, unit letter capture and the
// per-invoice snapshot register. Depends on iap_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "invoice_amount_parser_assert.svh"

module iap_parse import iap_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAR_W-1:0] character,
	input  logic              last_char,
	input  logic              dn_ready,
	output logic              snap_valid,
	output snap_t             snap
);

	typedef enum logic [2:0] {
		UNIT_NONE  = 3'd0,
		UNIT_M     = 3'd1,
		UNIT_U     = 3'd2,
		UNIT_N     = 3'd3,
		UNIT_P     = 3'd4,
		UNIT_OTHER = 3'd5
	} unit_t;

	localparam int HIST_N = 4;

	localparam logic [CHAR_W-1:0] CH_0  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_M  = 8'h6D;
	localparam logic [CHAR_W-1:0] CH_U  = 8'h75;
	localparam logic [CHAR_W-1:0] CH_N  = 8'h6E;
	localparam logic [CHAR_W-1:0] CH_P  = 8'h70;

	// decimal digits added or removed by each unit
	localparam logic [FLASH_W-1:0] EXP_M = FLASH_W'(5);
	localparam logic [FLASH_W-1:0] EXP_U = FLASH_W'(2);
	localparam logic [FLASH_W-1:0] EXP_N = FLASH_W'(1);
	localparam logic [FLASH_W-1:0] EXP_P = FLASH_W'(4);

	phase_t             phase_q, phase_d;
	logic [ACC_W-1:0]   acc_q, acc_upd, acc_x10;
	logic [ACC_W-1:0]   hist_q [HIST_N];
	logic [ACC_W-1:0]   hist_upd [HIST_N];
	logic [CNT_W-1:0]   cnt_q, cnt_upd;
	logic [CNT_W-1:0]   sig_q, sig_upd;
	unit_t              unit_q, unit_upd, letter_unit;
	logic               ovf_q, ovf_upd;
	logic               is_digit, is_letter, take, unit_hit, room, in_fire;
	logic [3:0]         digit_val;
	logic [FLASH_W-1:0] sig_wide, sig_res;
	snap_t              snap_d, snap_s1;
	logic               snap_valid_s1;

	// handshake: hold the input only when the snapshot cannot move on
	assign in_stall   = snap_valid_s1 && !dn_ready;
	assign in_fire    = in_valid && !in_stall;
	assign snap_valid = snap_valid_s1;
	assign snap       = snap_s1;

	// character classes
	assign is_digit  = (character >= CH_0) && (character <= CH_9);
	assign is_letter = ((character >= CH_LA) && (character <= CH_LZ)) ||
	                   ((character >= CH_UA) && (character <= CH_UZ));
	assign digit_val = character[3:0];

	always_comb begin
		unique case (character)
			CH_M:    letter_unit = UNIT_M;
			CH_U:    letter_unit = UNIT_U;
			CH_N:    letter_unit = UNIT_N;
			CH_P:    letter_unit = UNIT_P;
			default: letter_unit = UNIT_OTHER;
		endcase
	end

	// phase next state
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_SEEK_DIGIT: begin
				if (is_digit) begin
					phase_d = PH_DIGITS;
				end
			end
			PH_DIGITS: begin
				if (is_letter) begin
					phase_d = PH_DONE;
				end else if (!is_digit) begin
					phase_d = PH_SEEK_UNIT;
				end
			end
			PH_SEEK_UNIT: begin
				if (is_letter) begin
					phase_d = PH_DONE;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_SEEK_DIGIT;
			end
		endcase
	end

	// phase outputs: digit take and unit capture strobes
	always_comb begin
		take     = 1'b0;
		unit_hit = 1'b0;
		unique case (phase_q)
			PH_SEEK_DIGIT: begin
				take = is_digit;
			end
			PH_DIGITS: begin
				take     = is_digit;
				unit_hit = !is_digit && is_letter;
			end
			PH_SEEK_UNIT: begin
				unit_hit = is_letter;
			end
			default: begin
				take     = 1'b0;
				unit_hit = 1'b0;
			end
		endcase
	end

	// accumulator update; hist keeps the value before each of the last
	// four digits, which gives amount/10 and amount/10000 without dividing
	assign acc_x10 = {acc_q[ACC_W-4:0], 3'b000} + {acc_q[ACC_W-2:0], 1'b0};
	assign room    = cnt_q < CNT_W'(MAX_DIGITS);

	always_comb begin
		acc_upd  = acc_q;
		cnt_upd  = cnt_q;
		sig_upd  = sig_q;
		ovf_upd  = ovf_q;
		unit_upd = unit_q;
		for (int i = 0; i < HIST_N; i++) begin
			hist_upd[i] = hist_q[i];
		end
		if (take) begin
			if (room) begin
				acc_upd     = acc_x10 + ACC_W'(digit_val);
				cnt_upd     = cnt_q + CNT_W'(1);
				hist_upd[0] = acc_q;
				for (int i = 1; i < HIST_N; i++) begin
					hist_upd[i] = hist_q[i-1];
				end
				// significant digits: leading zeros do not count
				if (sig_q == '0) begin
					sig_upd = CNT_W'(digit_val != 4'd0);
				end else begin
					sig_upd = sig_q + CNT_W'(1);
				end
			end else begin
				ovf_upd = 1'b1;
			end
		end
		if (unit_hit) begin
			unit_upd = letter_unit;
		end
	end

	// result for an invoice ending with this character
	assign sig_wide = FLASH_W'(sig_upd);

	always_comb begin
		snap_d.status  = ST_OK;
		snap_d.operand = '0;
		snap_d.scale   = SC_ONE;
		sig_res        = '0;
		if (phase_d == PH_SEEK_DIGIT) begin
			snap_d.status = ST_NO_DIGITS;
		end else if (ovf_upd) begin
			snap_d.status = ST_OVERFLOW;
		end else begin
			case (unit_upd)
				UNIT_M: begin
					snap_d.operand = acc_upd;
					snap_d.scale   = SC_M;
					sig_res        = (sig_wide == '0) ? '0 : sig_wide + EXP_M;
				end
				UNIT_U: begin
					snap_d.operand = acc_upd;
					snap_d.scale   = SC_U;
					sig_res        = (sig_wide == '0) ? '0 : sig_wide + EXP_U;
				end
				UNIT_N: begin
					snap_d.operand = hist_upd[0];
					sig_res        = (sig_wide > EXP_N) ? sig_wide - EXP_N : '0;
				end
				UNIT_P: begin
					snap_d.operand = hist_upd[HIST_N-1];
					sig_res        = (sig_wide > EXP_P) ? sig_wide - EXP_P : '0;
				end
				default: begin
					snap_d.status = ST_UNIT_ERR;
				end
			endcase
		end
		snap_d.flash = (sig_res == '0) ? FLASH_W'(1) : sig_res;
	end

	// parse state; the last character of an invoice returns it to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK_DIGIT;
			acc_q   <= '0;
			cnt_q   <= '0;
			sig_q   <= '0;
			ovf_q   <= 1'b0;
			unit_q  <= UNIT_NONE;
			for (int i = 0; i < HIST_N; i++) begin
				hist_q[i] <= '0;
			end
		end else if (in_fire) begin
			if (last_char) begin
				phase_q <= PH_SEEK_DIGIT;
				acc_q   <= '0;
				cnt_q   <= '0;
				sig_q   <= '0;
				ovf_q   <= 1'b0;
				unit_q  <= UNIT_NONE;
				for (int i = 0; i < HIST_N; i++) begin
					hist_q[i] <= '0;
				end
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_upd;
				cnt_q   <= cnt_upd;
				sig_q   <= sig_upd;
				ovf_q   <= ovf_upd;
				unit_q  <= unit_upd;
				for (int i = 0; i < HIST_N; i++) begin
					hist_q[i] <= hist_upd[i];
				end
			end
		end
	end

	// snapshot stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (in_fire && last_char) begin
			snap_valid_s1 <= 1'b1;
		end else if (dn_ready) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && last_char) begin
			snap_s1 <= snap_d;
		end
	end

	`IAP_ASSERT(a_seek_clean, clk, arst_n, phase_q == PH_SEEK_DIGIT |-> cnt_q == '0 && sig_q == '0 && !ovf_q && unit_q == UNIT_NONE, "state left over while seeking first digit")
	`IAP_ASSERT(a_ovf_full, clk, arst_n, ovf_q |-> cnt_q == CNT_W'(MAX_DIGITS), "overflow flagged before digit run filled")
	`IAP_ASSERT(a_sig_le_cnt, clk, arst_n, sig_q <= cnt_q, "significant digits exceed digits taken")
	`IAP_ASSERT(a_last_resets, clk, arst_n, in_fire && last_char |=> snap_valid_s1 && phase_q == PH_SEEK_DIGIT, "last character did not close the invoice")

endmodule

`default_nettype wire

>>> src/iap_scale.sv
// Scale stage: multiplies the captured amount by the unit factor and holds
// the result item for the output channel. Depends on iap_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "invoice_amount_parser_assert.svh"

module iap_scale import iap_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               snap_valid,
	input  snap_t              snap,
	output logic               up_ready,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [SAT_W-1:0]   satoshis,
	output logic [FLASH_W-1:0] flash_count
);

	logic [FACTOR_W-1:0] factor;
	logic [SAT_W-1:0]    prod;
	logic                out_valid_s2;
	status_t             status_s2;
	logic [SAT_W-1:0]    sats_s2;
	logic [FLASH_W-1:0]  flash_s2;

	// output register empties or is taken this cycle
	assign up_ready = !out_valid_s2 || !out_stall;

	// unit factor decode
	always_comb begin
		unique case (snap.scale)
			SC_M:    factor = FACTOR_M;
			SC_U:    factor = FACTOR_U;
			default: factor = FACTOR_ONE;
		endcase
	end

	// 40 x 17 product fits the 57-bit field exactly
	assign prod = SAT_W'(snap.operand) * SAT_W'(factor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (up_ready) begin
			out_valid_s2 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && snap_valid) begin
			status_s2 <= snap.status;
			sats_s2   <= prod;
			flash_s2  <= snap.flash;
		end
	end

	assign out_valid   = out_valid_s2;
	assign status      = status_s2;
	assign satoshis    = sats_s2;
	assign flash_count = flash_s2;

	`IAP_ASSERT(a_err_zero, clk, arst_n, out_valid_s2 && status_s2 != ST_OK |-> sats_s2 == '0 && flash_s2 == FLASH_W'(1), "error item carries an amount")
	`IAP_ASSERT_NEVER(a_zero_flash, clk, arst_n, out_valid_s2 && sats_s2 == '0 && flash_s2 != FLASH_W'(1), "zero amount with flash count other than one")
	`IAP_ASSERT(a_hold, clk, arst_n, out_valid_s2 && out_stall |=> out_valid_s2 && $stable(sats_s2) && $stable(flash_s2), "stalled result item changed")

endmodule

`default_nettype wire

>>> src/invoice_amount_parser.sv
// Top level of the invoice amount parser: parse stage feeding scale stage.
// Depends on iap_pkg, iap_parse and iap_scale.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   character, last_char
//   output   out        out_valid / out_stall status, satoshis, flash_count
//
// One character is taken every cycle while in_stall is low; there is no gap between invoices.
// The result item of an invoice, once its last character is accepted, is held
// first in the snapshot register, then passes the multiplier feeding the
// output register.
// Reset clears the parse state and both valid flags; no item is in flight.
// A stalled output backs up through the snapshot register to in_stall.
`timescale 1ns / 1ps
`default_nettype none

module invoice_amount_parser import iap_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CHAR_W-1:0]  character,
	input  logic               last_char,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [SAT_W-1:0]   satoshis,
	output logic [FLASH_W-1:0] flash_count
);

	logic  snap_valid;
	logic  scale_ready;
	snap_t snap;

	iap_parse #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.character  (character),
		.last_char  (last_char),
		.dn_ready   (scale_ready),
		.snap_valid (snap_valid),
		.snap       (snap)
	);

	iap_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.snap_valid  (snap_valid),
		.snap        (snap),
		.up_ready    (scale_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.satoshis    (satoshis),
		.flash_count (flash_count)
	);

endmodule

`default_nettype wire

>>> dv/invoice_amount_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for invoice_amount_parser: random invoice text in, amounts checked.
// Depends on iap_pkg and the invoice_amount_parser RTL; standalone otherwise.

module invoice_amount_parser_tb;
	import iap_pkg::*;

	localparam int MAX_DIGITS = MAX_DIGITS_DEF;
	localparam int RUN_LIMIT_NS = 1_000_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_CHARS = 330;

	localparam logic [7:0] CH_0 = "0";
	localparam logic [7:0] CH_9 = "9";
	localparam logic [7:0] CH_LC_A = "a";
	localparam logic [7:0] CH_UC_A = "A";
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef enum logic [2:0] {
		UNIT_NONE,
		UNIT_M,
		UNIT_U,
		UNIT_N,
		UNIT_P,
		UNIT_OTHER
	} unit_t;

	typedef struct {
		status_t            status;
		logic [SAT_W-1:0]   sats;
		logic [FLASH_W-1:0] flash;
	} invoice_result_t;

	// Amount predictor plus the queue of amounts still owed by the block
	class amount_scoreboard;
		phase_t            stage;
		logic [ACC_W-1:0]  acc;
		int unsigned       ndigits;
		unit_t             unit;
		bit                ovf;
		invoice_result_t   amounts_q[$];
		int unsigned       mismatches;

		function new();
			mismatches = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			stage = PH_SEEK_DIGIT;
			acc = '0;
			ndigits = 0;
			unit = UNIT_NONE;
			ovf = 1'b0;
		endfunction

		function int pending();
			return amounts_q.size();
		endfunction

		function void take_digit(logic [3:0] d);
			if (ndigits >= MAX_DIGITS) begin
				ovf = 1'b1;
			end else begin
				acc = acc * 10 + d;
				ndigits++;
			end
		endfunction

		function void take_unit(logic [7:0] ch);
			bit is_letter;
			is_letter = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
			if (!is_letter) begin
				stage = PH_SEEK_UNIT;
				return;
			end
			stage = PH_DONE;
			case (ch)
				"m": unit = UNIT_M;
				"u": unit = UNIT_U;
				"n": unit = UNIT_N;
				"p": unit = UNIT_P;
				default: unit = UNIT_OTHER;
			endcase
		endfunction

		// one accepted character; an amount is owed on the last one
		function void note_char(logic [7:0] ch, bit last);
			bit is_digit;
			invoice_result_t res;
			logic [63:0] amount;
			logic [63:0] scaled;
			logic [SAT_W-1:0] rest;
			is_digit = ch >= CH_0 && ch <= CH_9;
			case (stage)
				PH_SEEK_DIGIT: begin
					if (is_digit) begin
						stage = PH_DIGITS;
						take_digit(4'(ch - CH_0));
					end
				end
				PH_DIGITS: begin
					if (is_digit) take_digit(4'(ch - CH_0));
					else take_unit(ch);
				end
				PH_SEEK_UNIT: take_unit(ch);
				default: ;
			endcase
			if (!last) return;

			scaled = '0;
			res.flash = 1;
			// no digits wins over overflow, overflow over a bad unit
			if (stage == PH_SEEK_DIGIT) begin
				res.status = ST_NO_DIGITS;
			end else if (ovf) begin
				res.status = ST_OVERFLOW;
			end else begin
				amount = 64'(acc);
				res.status = ST_OK;
				case (unit)
					UNIT_M: scaled = amount * 100000;
					UNIT_U: scaled = amount * 100;
					UNIT_N: scaled = amount / 10;
					UNIT_P: scaled = amount / 10000;
					default: res.status = ST_UNIT_ERR;
				endcase
			end
			res.sats = scaled[SAT_W-1:0];
			if (res.status == ST_OK && res.sats != 0) begin
				res.flash = 0;
				for (rest = res.sats; rest != 0; rest = rest / 10) res.flash++;
			end
			amounts_q = {amounts_q, res};
			clear_parse();
		endfunction

		task report(string msg);
			mismatches++;
			$display("%0t ns  mismatch: %s", $time, msg);
		endtask

		task check_result(logic [1:0] st, logic [SAT_W-1:0] sats, logic [FLASH_W-1:0] fl);
			invoice_result_t want;
			if (amounts_q.size() == 0) begin
				report($sformatf("result with none owed: status %0d satoshis %0d flash %0d",
					st, sats, fl));
				return;
			end
			want = amounts_q.pop_front();
			if (st !== want.status)
				report($sformatf("status %0d, want %0d", st, want.status));
			if (sats !== want.sats)
				report($sformatf("satoshis %0d, want %0d", sats, want.sats));
			if (fl !== want.flash)
				report($sformatf("flash_count %0d, want %0d", fl, want.flash));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [CHAR_W-1:0]  character;
	logic               last_char;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [SAT_W-1:0]   satoshis;
	logic [FLASH_W-1:0] flash_count;

	amount_scoreboard sb = new();
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned chars_sent = 0;

	invoice_amount_parser #(
		.MAX_DIGITS(MAX_DIGITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.character(character),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.satoshis(satoshis),
		.flash_count(flash_count)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// receiver: random stall, decided at the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, satoshis, flash_count);
	end

	// one item: optional idle gap, then hold until accepted; starts and ends at a falling edge
	task automatic send_char(input logic [7:0] ch, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		character <= ch;
		last_char <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_char(ch, last);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] any_non_digit();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (c >= CH_0 && c <= CH_9);
		return c;
	endfunction

	function automatic logic [7:0] any_non_alnum();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while ((c >= CH_0 && c <= CH_9) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
		return c;
	endfunction

	function automatic logic [7:0] any_letter();
		int unsigned k;
		k = $urandom_range(51);
		return (k < 26) ? CH_LC_A + 8'(k) : CH_UC_A + 8'(k - 26);
	endfunction

	// mostly well-formed invoices with random content, some pure noise
	task automatic send_random_invoice();
		logic [7:0] text[$];
		logic [7:0] unit_ch;
		int unsigned pick;
		int unsigned n_digits;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(8, 1)) text = {text, 8'($urandom_range(255))};
		end else begin
			pick = $urandom_range(3);
			if (pick == 0) begin
				text = {text, 8'("l")};
				text = {text, 8'("n")};
				text = {text, 8'("b")};
				text = {text, 8'("c")};
			end else begin
				repeat (pick - 1) text = {text, any_non_digit()};
			end

			pick = $urandom_range(19);
			if (pick == 0) n_digits = 0;
			else if (pick == 1) n_digits = $urandom_range(MAX_DIGITS + 3, MAX_DIGITS + 1);
			else if (pick < 10) n_digits = $urandom_range(4, 1);
			else n_digits = $urandom_range(MAX_DIGITS, 1);
			repeat (n_digits) text = {text, 8'(CH_0 + 8'($urandom_range(9)))};

			if ($urandom_range(7) == 0)
				repeat ($urandom_range(2, 1)) text = {text, any_non_alnum()};

			pick = $urandom_range(11);
			case (pick % 4)
				0: unit_ch = "m";
				1: unit_ch = "u";
				2: unit_ch = "n";
				default: unit_ch = "p";
			endcase
			if (pick < 8) text = {text, unit_ch};
			else if (pick == 8) text = {text, 8'(unit_ch - CASE_BIT)};
			else if (pick < 11) text = {text, any_letter()};

			repeat ($urandom_range(6)) text = {text, 8'($urandom_range(255))};
		end
		if (text.size() == 0) text = {text, 8'($urandom_range(255))};
		foreach (text[i]) send_char(text[i], i == text.size() - 1);
	endtask

	// random traffic, then hold off the sender until every amount is back
	task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
		int unsigned start;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = chars_sent;
		while (chars_sent - start < PHASE_CHARS) send_random_invoice();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		character = '0;
		last_char = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: every unit, case errors, separators, extremes
		send_text("5m");
		send_text("q3u");
		send_text("25n");
		send_text("1p");
		send_text("x");
		send_text("4M");
		send_text("6-u");
		send_text("7");
		send_text("999999999999m");
		send_text("1234567890123u");
		send_char(8'h00, 1'b0);
		send_char("8", 1'b0);
		send_char(8'hFF, 1'b1);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);

		run_phase(33, 77);
		run_phase(77, 33);
		run_phase(0, 0);

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("invoice_amount_parser verification clean");
		else
			$display("invoice_amount_parser verification failed");
		$finish;
	end

	// hard stop if the block hangs
	initial begin
		#(RUN_LIMIT_NS);
		$display("invoice_amount_parser verification failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/iap_pkg.sv
src/iap_parse.sv
src/iap_scale.sv
src/invoice_amount_parser.sv
dv/invoice_amount_parser_tb.sv
